@@ hw/rtl/lasc_pkg.sv @@
// Shared types, constants and the inverse S-box for the subkey counter.
`timescale 1ns / 1ps

package lasc_pkg;

  localparam int CANDIDATES = 16;
  localparam int IDX_BITS   = $clog2(CANDIDATES);
  localparam int SAMPLE_BITS = 16;

  // configuration register indexes
  localparam logic REG_PLAINTEXT_MASK = 1'b0;
  localparam logic REG_STATE_MASK     = 1'b1;

  localparam logic [7:0] PLAINTEXT_MASK_RESET = 8'h10;
  localparam logic [7:0] STATE_MASK_RESET     = 8'h0E;

  typedef struct packed {
    logic [7:0] plain_byte;
    logic [7:0] cipher_byte;
    logic       last_pair;
  } in_t;

  typedef struct packed {
    logic [3:0]  best_subkey;
    logic [15:0] doubled_bias;
    logic [15:0] samples_seen;
    logic        count_overflow;
  } out_t;

  typedef struct packed {
    logic count;      // accept a pair and update all lanes
    logic scan_init;  // reset the bias search
    logic scan_step;  // evaluate one candidate
    logic finish;     // capture the result and clear the run
  } cmd_t;

  typedef struct packed {
    logic scan_last;
  } status_t;

  // inverse of S-box E4D12FB83A6C5907
  function automatic logic [3:0] inv_sbox(input logic [3:0] x);
    logic [3:0] r;
    case (x)
      4'h0: r = 4'hE;
      4'h1: r = 4'h3;
      4'h2: r = 4'h4;
      4'h3: r = 4'h8;
      4'h4: r = 4'h1;
      4'h5: r = 4'hC;
      4'h6: r = 4'hA;
      4'h7: r = 4'hF;
      4'h8: r = 4'h7;
      4'h9: r = 4'hD;
      4'hA: r = 4'h9;
      4'hB: r = 4'h6;
      4'hC: r = 4'hB;
      4'hD: r = 4'h2;
      4'hE: r = 4'h0;
      4'hF: r = 4'h5;
      default: r = 4'h0;
    endcase
    return r;
  endfunction

endpackage

@@ hw/rtl/lasc_datapath.sv @@
// Datapath: config registers, 16 match-counter lanes and the serial bias search.
`timescale 1ns / 1ps

module lasc_datapath #(
  parameter int COUNTER_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  lasc_pkg::cmd_t     cmd,
  output lasc_pkg::status_t  status,
  input  lasc_pkg::in_t      item,
  input  logic               cfg_we,
  input  logic               cfg_addr,
  input  logic [7:0]         cfg_data,
  output lasc_pkg::out_t     result
);

  localparam int BW = (COUNTER_BITS + 1 > lasc_pkg::SAMPLE_BITS + 1) ?
                      COUNTER_BITS + 1 : lasc_pkg::SAMPLE_BITS + 1;
  localparam logic [COUNTER_BITS-1:0] CNT_MAX = '1;
  localparam logic [lasc_pkg::SAMPLE_BITS-1:0] SAMPLE_MAX = '1;
  localparam logic [BW-1:0] BIAS_CAP = BW'(SAMPLE_MAX);

  logic [7:0] plaintext_mask;
  logic [7:0] state_mask;

  logic [COUNTER_BITS-1:0]          counts [lasc_pkg::CANDIDATES];
  logic [lasc_pkg::SAMPLE_BITS-1:0] sample_total;
  logic                             saturated_flag;

  logic [lasc_pkg::IDX_BITS-1:0] scan_idx;
  logic [lasc_pkg::IDX_BITS-1:0] best;
  logic [BW-1:0]                 best_bias;

  logic                          plain_par;
  logic [3:0]                    hi_nib;
  logic [lasc_pkg::CANDIDATES-1:0] hit;
  logic                          any_sat;

  logic [BW-1:0]                 twice;
  logic [BW-1:0]                 n_ext;
  logic [BW-1:0]                 bias;
  logic                          better;
  logic [lasc_pkg::IDX_BITS-1:0] best_next;
  logic [BW-1:0]                 best_bias_next;

  assign plain_par = ^(item.plain_byte & plaintext_mask);
  assign hi_nib    = lasc_pkg::inv_sbox(item.cipher_byte[7:4]);

  always_comb begin
    any_sat = 1'b0;
    for (int k = 0; k < lasc_pkg::CANDIDATES; k++) begin
      logic [3:0] lo;
      lo = lasc_pkg::inv_sbox(item.cipher_byte[3:0] ^ 4'(k));
      hit[k] = ((^({hi_nib, lo} & state_mask)) == plain_par);
      if (hit[k] && counts[k] == CNT_MAX) begin
        any_sat = 1'b1;
      end
    end
  end

  // one candidate per cycle: |2*count - samples| against the running best
  assign twice  = BW'({counts[scan_idx], 1'b0});
  assign n_ext  = BW'(sample_total);
  assign bias   = (twice >= n_ext) ? twice - n_ext : n_ext - twice;
  assign better = bias > best_bias;
  assign best_next      = better ? scan_idx : best;
  assign best_bias_next = better ? bias : best_bias;

  assign status.scan_last = (scan_idx == lasc_pkg::IDX_BITS'(lasc_pkg::CANDIDATES - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      plaintext_mask <= lasc_pkg::PLAINTEXT_MASK_RESET;
      state_mask     <= lasc_pkg::STATE_MASK_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        lasc_pkg::REG_PLAINTEXT_MASK: plaintext_mask <= cfg_data;
        lasc_pkg::REG_STATE_MASK:     state_mask     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.finish) begin
      for (int k = 0; k < lasc_pkg::CANDIDATES; k++) begin
        counts[k] <= '0;
      end
      sample_total   <= '0;
      saturated_flag <= 1'b0;
    end else if (cmd.count) begin
      for (int k = 0; k < lasc_pkg::CANDIDATES; k++) begin
        if (hit[k] && counts[k] != CNT_MAX) begin
          counts[k] <= counts[k] + 1'b1;
        end
      end
      if (sample_total != SAMPLE_MAX) begin
        sample_total <= sample_total + 1'b1;
      end
      if (any_sat) begin
        saturated_flag <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.scan_init) begin
      scan_idx  <= '0;
      best      <= '0;
      best_bias <= '0;
    end else if (cmd.scan_step) begin
      scan_idx  <= scan_idx + 1'b1;
      best      <= best_next;
      best_bias <= best_bias_next;
    end
  end

  // result register, loaded on the last search step
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      result.best_subkey    <= 4'(best_next);
      result.doubled_bias   <= (best_bias_next > BIAS_CAP) ? SAMPLE_MAX :
                               best_bias_next[lasc_pkg::SAMPLE_BITS-1:0];
      result.samples_seen   <= sample_total;
      result.count_overflow <= saturated_flag;
    end
  end

endmodule

@@ hw/rtl/lasc_ctrl.sv @@
// Controller: sequences counting, the bias search and the result strobe.
`timescale 1ns / 1ps

module lasc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              last_pair,
  output logic              busy,
  output logic              done,
  output lasc_pkg::cmd_t    cmd,
  input  lasc_pkg::status_t status
);

  typedef enum logic {
    IDLE,
    SCAN
  } state_t;

  state_t state;

  assign busy = (state == SCAN);

  always_comb begin
    cmd.count     = start && (state == IDLE);
    cmd.scan_init = cmd.count && last_pair;
    cmd.scan_step = (state == SCAN);
    cmd.finish    = cmd.scan_step && status.scan_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        IDLE: begin
          if (cmd.scan_init) begin
            state <= SCAN;
          end
        end
        SCAN: begin
          if (status.scan_last) begin
            state <= IDLE;
            done  <= 1'b1;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

@@ hw/rtl/linear_approx_subkey_counter_core.sv @@
// Top level of the linear-approximation partial subkey counter.
// A pair is taken when start is high while idle, and pairs without the last mark may
// follow back to back. A last pair starts a search over the 16 counters (one candidate
// per cycle); busy is high throughout, and done strobes in the cycle after the last
// search step, with the result. The receiver cannot stall.
// Synchronous reset clears counters and flags and reloads the mask registers.
`timescale 1ns / 1ps

module linear_approx_subkey_counter_core #(
  parameter int COUNTER_BITS = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  lasc_pkg::in_t  item,
  output logic           done,
  output lasc_pkg::out_t result,
  input  logic           cfg_we,
  input  logic           cfg_addr,
  input  logic [7:0]     cfg_data
);

  lasc_pkg::cmd_t    cmd;
  lasc_pkg::status_t status;

  lasc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .last_pair (item.last_pair),
    .busy      (busy),
    .done      (done),
    .cmd       (cmd),
    .status    (status)
  );

  lasc_datapath #(
    .COUNTER_BITS (COUNTER_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .item     (item),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .result   (result)
  );

  // a result needs a full search, so strobes never come back to back
  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done strobed twice in a row");

  a_last_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && item.last_pair) |=> busy)
    else $error("last pair did not start the search");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without a search");

  // the best index only moves off zero on a strictly larger bias
  a_zero_bias: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.best_subkey == 4'd0 || result.doubled_bias != 16'd0))
    else $error("nonzero subkey reported with zero bias");

endmodule

@@ sim/subkey_rank_checker.sv @@
// Checker for the subkey counter: predicts each ranking beat and compares it with the DUT.
`timescale 1ns / 1ps

module subkey_rank_checker #(
  parameter int COUNTER_BITS = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic           busy,
  input  lasc_pkg::in_t  item,
  input  logic           done,
  input  lasc_pkg::out_t result,
  input  logic           cfg_we,
  input  logic           cfg_addr,
  input  logic [7:0]     cfg_data,
  output int unsigned    mismatches,
  output int unsigned    rankings_owed
);

  // inverse S-box, entry i in bits [4i+3:4i]
  localparam logic [63:0] UNSBOX = 64'h502B69D7_FAC1843E;

  logic [7:0]              pt_mask;
  logic [7:0]              st_mask;
  logic [COUNTER_BITS-1:0] tally [lasc_pkg::CANDIDATES];
  logic [15:0]             pair_count;
  logic                    sat_seen;
  lasc_pkg::out_t          rankings_due [$];
  int unsigned             err_total = 0;

  initial begin
    mismatches    = 0;
    rankings_owed = 0;
  end

  task automatic clear_run();
    int k;
    for (k = 0; k < lasc_pkg::CANDIDATES; k++) tally[k] = '0;
    pair_count = '0;
    sat_seen   = 1'b0;
  endtask

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    $display("ERROR %0t ns: %s got %0d, want %0d", $time, what, got, want);
    err_total++;
  endtask

  // count one pair on all lanes; on the last pair rank the candidates
  task automatic tally_pair(input lasc_pkg::in_t pr);
    logic            plain_par;
    logic [7:0]      x;
    logic [7:0]      r;
    longint unsigned twice;
    longint unsigned n;
    longint unsigned b;
    longint unsigned best_bias;
    logic [3:0]      best;
    lasc_pkg::out_t  ranking;
    int              k;
    plain_par = ^(pr.plain_byte & pt_mask);
    for (k = 0; k < lasc_pkg::CANDIDATES; k++) begin
      x = pr.cipher_byte ^ {4'h0, k[3:0]};
      r = {UNSBOX[x[7:4]*4 +: 4], UNSBOX[x[3:0]*4 +: 4]};
      if ((^(r & st_mask)) == plain_par) begin
        if (tally[k] == {COUNTER_BITS{1'b1}}) sat_seen = 1'b1;
        else tally[k] = tally[k] + 1'b1;
      end
    end
    if (pair_count != 16'hFFFF) pair_count = pair_count + 1'b1;
    if (pr.last_pair) begin
      best      = '0;
      best_bias = 0;
      n         = pair_count;
      for (k = 0; k < lasc_pkg::CANDIDATES; k++) begin
        twice = 2 * longint'(tally[k]);
        b = (twice >= n) ? twice - n : n - twice;
        if (b > best_bias) begin
          best_bias = b;
          best      = k[3:0];
        end
      end
      if (best_bias > 65535) best_bias = 65535;
      ranking.best_subkey    = best;
      ranking.doubled_bias   = best_bias[15:0];
      ranking.samples_seen   = pair_count;
      ranking.count_overflow = sat_seen;
      rankings_due.push_back(ranking);
      clear_run();
    end
  endtask

  task automatic check_ranking(input lasc_pkg::out_t got);
    lasc_pkg::out_t want;
    if (rankings_due.size() == 0) begin
      report_mismatch("result beat with none pending, best_subkey", got.best_subkey, 0);
    end else begin
      want = rankings_due.pop_front();
      if (got.best_subkey !== want.best_subkey)
        report_mismatch("best_subkey", got.best_subkey, want.best_subkey);
      if (got.doubled_bias !== want.doubled_bias)
        report_mismatch("doubled_bias", got.doubled_bias, want.doubled_bias);
      if (got.samples_seen !== want.samples_seen)
        report_mismatch("samples_seen", got.samples_seen, want.samples_seen);
      if (got.count_overflow !== want.count_overflow)
        report_mismatch("count_overflow", got.count_overflow, want.count_overflow);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_run();
      pt_mask = lasc_pkg::PLAINTEXT_MASK_RESET;
      st_mask = lasc_pkg::STATE_MASK_RESET;
      rankings_due.delete();
    end else begin
      if (done === 1'b1) check_ranking(result);
      // a pair taken at this edge still sees the old masks
      if (start && !busy) tally_pair(item);
      if (cfg_we) begin
        case (cfg_addr)
          lasc_pkg::REG_PLAINTEXT_MASK: pt_mask = cfg_data;
          lasc_pkg::REG_STATE_MASK:     st_mask = cfg_data;
          default: ;
        endcase
      end
    end
    // nonblocking so the stimulus side always sees the pre-edge values
    mismatches    <= err_total;
    rankings_owed <= rankings_due.size();
  end

endmodule

@@ sim/tb_linear_approx_subkey_counter_core.sv @@
// Testbench top for the subkey counter core: stimulus, configuration and verdict.
`timescale 1ns / 1ps

module tb_linear_approx_subkey_counter_core;

  localparam int CNT_BITS     = 16;
  localparam int RANDOM_PAIRS = 1000;
  localparam int LONG_PAIRS   = 300;
  localparam int SETTLE       = 24;  // idle wait added after the pending results are out

  logic           clk;
  logic           rst      = 1'b1;
  logic           start    = 1'b0;
  lasc_pkg::in_t  item     = '0;
  logic           cfg_we   = 1'b0;
  logic           cfg_addr = lasc_pkg::REG_PLAINTEXT_MASK;
  logic [7:0]     cfg_data = '0;
  logic           busy;
  logic           done;
  lasc_pkg::out_t result;
  int unsigned    mismatches;
  int unsigned    rankings_owed;

  logic        burst = 1'b0;
  int          pairs_sent;

  linear_approx_subkey_counter_core #(
    .COUNTER_BITS(CNT_BITS)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .item(item),
    .done(done),
    .result(result),
    .cfg_we(cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_data(cfg_data)
  );

  subkey_rank_checker #(
    .COUNTER_BITS(CNT_BITS)
  ) i_checker (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .item(item),
    .done(done),
    .result(result),
    .cfg_we(cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_data(cfg_data),
    .mismatches(mismatches),
    .rankings_owed(rankings_owed)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // present one pair, hold until accepted, then maybe idle
  task automatic send_pair(input logic [7:0] p, input logic [7:0] c, input logic lst);
    lasc_pkg::in_t pr;
    int  g;
    pr.plain_byte  = p;
    pr.cipher_byte = c;
    pr.last_pair   = lst;
    item  <= pr;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    pairs_sent++;
    g = idle_gap();
    if (g > 0) begin
      start <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // stop sending until every pending ranking has come out
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (rankings_owed != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] val);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we   <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_masks(input logic [7:0] pm, input logic [7:0] sm);
    drain();
    write_reg(lasc_pkg::REG_PLAINTEXT_MASK, pm);
    write_reg(lasc_pkg::REG_STATE_MASK, sm);
  endtask

  function automatic logic [7:0] pick_mask();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return 8'h00;
    if (r < 4) return 8'hFF;
    return 8'($urandom);
  endfunction

  initial begin
    int run_len;
    int r;
    int i;
    pairs_sent = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // reset masks: field extremes, then a one-pair run
    send_pair(8'h00, 8'h00, 1'b0);
    send_pair(8'hFF, 8'hFF, 1'b0);
    send_pair(8'h80, 8'h01, 1'b0);
    send_pair(8'h01, 8'h80, 1'b1);
    send_pair(8'h5A, 8'hA5, 1'b1);
    // empty masks: every lane matches, all tie
    set_masks(8'h00, 8'h00);
    send_pair(8'h12, 8'h34, 1'b0);
    send_pair(8'hFF, 8'h00, 1'b1);
    // one match per lane over two pairs: all biases zero
    set_masks(8'hFF, 8'h00);
    send_pair(8'h01, 8'h9C, 1'b0);
    send_pair(8'h00, 8'h63, 1'b1);
    // high nibble only: lanes tie with nonzero bias
    set_masks(8'h00, 8'hF0);
    send_pair(8'h00, 8'h37, 1'b0);
    send_pair(8'h00, 8'hC2, 1'b1);
    set_masks(8'hFF, 8'hFF);
    send_pair(8'hA5, 8'h0F, 1'b0);
    send_pair(8'h3C, 8'hF0, 1'b0);
    send_pair(8'hC3, 8'h5A, 1'b1);
    set_masks(8'h01, 8'h0F);
    send_pair(8'h01, 8'h7E, 1'b0);
    send_pair(8'hFE, 8'h81, 1'b1);

    // random runs of pairs, masks changed between some of them
    pairs_sent = 0;
    while (pairs_sent < RANDOM_PAIRS) begin
      r = $urandom_range(0, 7);
      if (r == 0) begin
        set_masks(pick_mask(), pick_mask());
      end else if (r == 1) begin
        drain();
        write_reg($urandom_range(0, 1) ? lasc_pkg::REG_STATE_MASK :
                  lasc_pkg::REG_PLAINTEXT_MASK, pick_mask());
      end else if (r == 2) begin
        drain();
      end
      burst = ($urandom_range(0, 4) == 0);
      r = $urandom_range(0, 9);
      if (r < 5) run_len = $urandom_range(1, 8);
      else if (r < 9) run_len = $urandom_range(9, 40);
      else run_len = $urandom_range(41, 150);
      for (i = 1; i <= run_len; i++)
        send_pair(8'($urandom), 8'($urandom), i == run_len);
    end
    burst = 1'b0;

    // one long back-to-back run with empty masks: every lane matches every pair
    set_masks(8'h00, 8'h00);
    burst = 1'b1;
    for (i = 1; i <= LONG_PAIRS; i++)
      send_pair(8'($urandom), 8'($urandom), i == LONG_PAIRS);
    burst = 1'b0;
    send_pair(8'($urandom), 8'($urandom), 1'b1);

    start <= 1'b0;
    for (i = 0; i < 2000 && rankings_owed != 0; i++) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (rankings_owed != 0) $display("ERROR: %0d results never arrived", rankings_owed);
    if (mismatches == 0 && rankings_owed == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
